@@ design/wffl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wffl_pkg;

  localparam int MAX_BLOCKS   = 32;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;

  localparam int ADDR_W = 16;
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  // A rounded request can reach one past the largest 16-bit value.
  localparam int NEED_W = ADDR_W + 1;

  // Rounding divides by ALIGN_BYTES through a reciprocal that is exact
  // for every NEED_W-bit dividend and any alignment below 128.
  localparam int RECIP_SH = NEED_W + 7;
  localparam longint RECIP = (64'd1 << RECIP_SH) / ALIGN_BYTES + 64'd1;
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int PROD_W  = NEED_W + RECIP_W;

  localparam logic [ADDR_W-1:0] HEAP_RESET = ADDR_W'(1000);
  localparam logic [ADDR_W-1:0] HDR        = ADDR_W'(HEADER_BYTES);
  localparam logic [NEED_W-1:0] SPLIT_MIN  = NEED_W'(HEADER_BYTES + ALIGN_BYTES);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FIT  = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_INIT  = 3'd1,
    CELL_PUSH  = 3'd2,
    CELL_PULL  = 3'd3,
    CELL_SPLIT = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pick;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ design/wffl_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface wffl_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] req_bytes;
  logic [15:0] free_addr;
  modport source (output valid, cmd, req_bytes, free_addr, input ready);
  modport sink (input valid, cmd, req_bytes, free_addr, output ready);
endinterface
`default_nettype wire

@@ design/wffl_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface wffl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] addr;
  modport source (output valid, status, addr, input ready);
  modport sink (input valid, status, addr, output ready);
endinterface
`default_nettype wire

@@ design/wffl_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface wffl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ design/worst_fit_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Worst-fit heap allocator. The free list is a row of cells, head first;
// a free shifts every cell one place toward the tail, and removing a block
// shifts the cells behind it one place toward the head. The PREP and MUL
// states round the size of each request; then one counter walks the free list
// and the allocated table together, one entry per cycle, and the UPD state
// updates both once the output register is free to take the result. A new
// request is taken once the result has entered the output register. Writing
// heap_size is accepted only while no request is being worked on, and a
// pending write holds off new requests; it resets the free list to one block
// (none if the size is below the header) and drops every allocation.
module worst_fit_free_list_allocator
  import wffl_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  wffl_in_if.sink   in_if,
  wffl_out_if.source out_if,
  wffl_cfg_if.sink  cfg_if
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  free_count_r;
  logic [ADDR_W-1:0] heap_r;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] req_r, faddr_r;
  logic [NEED_W-1:0] q_r, need_r, best_r;
  logic              found_r, slot_found_r;
  logic [IDX_W-1:0]  pick_r, slot_r;
  logic [ADDR_W-1:0] blk_start_r, blk_size_r;

  logic [ADDR_W-1:0] used_start_r [MAX_BLOCKS];
  logic [ADDR_W-1:0] used_size_r  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_valid_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [ADDR_W-1:0] cell_start [MAX_BLOCKS];
  logic [ADDR_W-1:0] cell_size  [MAX_BLOCKS];
  cell_cmd_t         ccmd;

  logic cfg_wr, in_acc, upd_go;
  logic [ADDR_W-1:0] init_heap;
  logic [NEED_W-1:0] round_in;
  logic [PROD_W-1:0] prod;
  logic [NEED_W+7:0] need_full;
  logic [NEED_W-1:0] slack;
  status_t           res_status;

  assign cfg_wr    = cfg_if.valid && cfg_if.ready;
  assign in_acc    = in_if.valid && in_if.ready;
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || out_if.ready);
  assign init_heap = cfg_wr ? cfg_if.data : HEAP_RESET;

  assign cfg_if.ready  = rst_n && (state_r == ST_IDLE);
  assign in_if.ready   = rst_n && (state_r == ST_IDLE) && !cfg_if.valid;
  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.addr   = out_addr_r;

  assign round_in  = NEED_W'(req_r) + NEED_W'(ALIGN_BYTES - 1);
  assign prod      = PROD_W'(round_in) * PROD_W'(RECIP);
  assign need_full = (NEED_W+8)'(q_r) * (NEED_W+8)'(ALIGN_BYTES);
  assign slack     = NEED_W'(blk_size_r) - need_r;

  // Cell row.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    wffl_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ccmd       (ccmd),
      .prev_start ((i == 0) ? ccmd.start : cell_start[(i == 0) ? 0 : i - 1]),
      .prev_size  ((i == 0) ? ccmd.size  : cell_size[(i == 0) ? 0 : i - 1]),
      .next_start (cell_start[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .next_size  (cell_size[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .start      (cell_start[i]),
      .size       (cell_size[i])
    );
  end

  always_comb begin
    res_status = STAT_OK;
    if (cmd_r == CMD_ALLOC) begin
      if (!found_r) res_status = STAT_NO_FIT;
      else if (!slot_found_r) res_status = STAT_FULL;
    end else begin
      if (!slot_found_r) res_status = STAT_UNKNOWN;
      else if (free_count_r == CNT_W'(MAX_BLOCKS)) res_status = STAT_FULL;
    end
  end

  always_comb begin
    ccmd.op    = CELL_HOLD;
    ccmd.pick  = pick_r;
    ccmd.start = faddr_r - HDR;
    ccmd.size  = blk_size_r;
    if (!rst_n || cfg_wr) begin
      ccmd.op    = CELL_INIT;
      ccmd.start = '0;
      ccmd.size  = init_heap - HDR;
    end else if (upd_go && res_status == STAT_OK) begin
      if (cmd_r == CMD_FREE) begin
        ccmd.op = CELL_PUSH;
      end else if (slack >= SPLIT_MIN) begin
        ccmd.op    = CELL_SPLIT;
        ccmd.start = blk_start_r + HDR + need_r[ADDR_W-1:0];
        ccmd.size  = blk_size_r - need_r[ADDR_W-1:0] - HDR;
      end else begin
        ccmd.op = CELL_PULL;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == IDX_W'(MAX_BLOCKS - 1)) state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      used_valid_r <= '0;
      heap_r       <= HEAP_RESET;
      free_count_r <= (HEAP_RESET >= HDR) ? CNT_W'(1) : '0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      if (state_r == ST_MUL) cnt_r <= '0;
      else if (state_r == ST_SCAN) cnt_r <= cnt_r + IDX_W'(1);
      if (cfg_wr) begin
        heap_r       <= cfg_if.data;
        used_valid_r <= '0;
        free_count_r <= (cfg_if.data >= HDR) ? CNT_W'(1) : '0;
      end else if (upd_go) begin
        if (res_status == STAT_OK) begin
          if (cmd_r == CMD_FREE) begin
            used_valid_r[slot_r] <= 1'b0;
            free_count_r         <= free_count_r + CNT_W'(1);
          end else begin
            used_valid_r[slot_r] <= 1'b1;
            if (slack < SPLIT_MIN) free_count_r <= free_count_r - CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= cmd_t'(in_if.cmd);
      req_r   <= in_if.req_bytes;
      faddr_r <= in_if.free_addr;
    end
    if (state_r == ST_PREP) q_r <= NEED_W'(prod >> RECIP_SH);
    if (state_r == ST_MUL) begin
      need_r       <= need_full[NEED_W-1:0];
      best_r       <= need_full[NEED_W-1:0];
      found_r      <= 1'b0;
      slot_found_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      if (cmd_r == CMD_ALLOC) begin
        if (CNT_W'(cnt_r) < free_count_r && NEED_W'(cell_size[cnt_r]) >= best_r) begin
          best_r      <= NEED_W'(cell_size[cnt_r]);
          pick_r      <= cnt_r;
          found_r     <= 1'b1;
          blk_start_r <= cell_start[cnt_r];
          blk_size_r  <= cell_size[cnt_r];
        end
        if (!slot_found_r && !used_valid_r[cnt_r]) begin
          slot_r       <= cnt_r;
          slot_found_r <= 1'b1;
        end
      end else if (!slot_found_r && used_valid_r[cnt_r] &&
                   used_start_r[cnt_r] == faddr_r) begin
        slot_r       <= cnt_r;
        slot_found_r <= 1'b1;
        blk_size_r   <= used_size_r[cnt_r];
      end
    end
    if (upd_go) begin
      out_status_r <= res_status;
      out_addr_r   <= (cmd_r == CMD_ALLOC && res_status == STAT_OK) ?
                      blk_start_r + HDR : '0;
      if (cmd_r == CMD_ALLOC && res_status == STAT_OK) begin
        used_start_r[slot_r] <= blk_start_r + HDR;
        used_size_r[slot_r]  <= need_r[ADDR_W-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= CNT_W'(MAX_BLOCKS))
    else $error("free list count beyond capacity");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && cnt_r == IDX_W'(MAX_BLOCKS - 1) |=> state_r == ST_UPD)
    else $error("scan did not end in update");
  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_OK |-> out_addr_r == '0)
    else $error("error result carries an address");
  a_heap_init: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> heap_r == $past(cfg_if.data) && used_valid_r == '0)
    else $error("heap size write did not reinitialize");
`endif

endmodule
`default_nettype wire

@@ design/wffl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wffl_cell
  import wffl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire cell_cmd_t         ccmd,
  input  wire logic [ADDR_W-1:0] prev_start,
  input  wire logic [ADDR_W-1:0] prev_size,
  input  wire logic [ADDR_W-1:0] next_start,
  input  wire logic [ADDR_W-1:0] next_size,
  output logic      [ADDR_W-1:0] start,
  output logic      [ADDR_W-1:0] size
);

  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt;

  always_comb begin
    start_nxt = start_r;
    size_nxt  = size_r;
    case (ccmd.op)
      CELL_INIT: begin
        start_nxt = ccmd.start;
        size_nxt  = ccmd.size;
      end
      CELL_PUSH: begin
        start_nxt = prev_start;
        size_nxt  = prev_size;
      end
      CELL_PULL: begin
        if (idx >= ccmd.pick) begin
          start_nxt = next_start;
          size_nxt  = next_size;
        end
      end
      CELL_SPLIT: begin
        if (idx == ccmd.pick) begin
          start_nxt = ccmd.start;
          size_nxt  = ccmd.size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
  end

  assign start = start_r;
  assign size  = size_r;

endmodule
`default_nettype wire
